### hdl/lrr_pkg.sv
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared constants for the linear congruential random range unit.
// ----------------------------------------------------------------------------
package lrr_pkg;

   localparam int LRR_WIDTH = 32;
   localparam int LRR_DIGIT_WIDTH = 4;

   localparam logic [LRR_WIDTH-1:0] LCG_MUL = 32'd1103515245;
   localparam logic [LRR_WIDTH-1:0] LCG_INC = 32'd12345;

   localparam logic [1:0] CMD_RAW   = 2'd0;
   localparam logic [1:0] CMD_MOD   = 2'd1;
   localparam logic [1:0] CMD_RANGE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } lrr_state_type;

endpackage

### hdl/lrr_if.sv
// ----------------------------------------------------------------------------
// lrr interfaces
// Valid/ready channels for requests, responses and the seed register.
// ----------------------------------------------------------------------------
interface lrr_req_if
   import lrr_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           cmd;
   logic [LRR_WIDTH-1:0] lower;
   logic [LRR_WIDTH-1:0] upper;

   modport source (output valid, output cmd, output lower, output upper, input ready);
   modport sink   (input valid, input cmd, input lower, input upper, output ready);
endinterface

interface lrr_rsp_if
   import lrr_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [LRR_WIDTH-1:0] value;
   logic                 zero_span;

   modport source (output valid, output value, output zero_span, input ready);
   modport sink   (input valid, input value, input zero_span, output ready);
endinterface

interface lrr_csr_if
   import lrr_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [LRR_WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hdl/lrr_mul.sv
// ----------------------------------------------------------------------------
// lrr_mul
// Digit-serial state advance: s * LCG_MUL + LCG_INC, one digit per cycle.
// ----------------------------------------------------------------------------
module lrr_mul
   import lrr_pkg::*;
#(
   parameter int DIGIT_WIDTH = LRR_DIGIT_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [LRR_WIDTH-1:0] state_in,
   output logic [LRR_WIDTH-1:0] result,
   output logic                 done
);

   localparam int STEPS = LRR_WIDTH / DIGIT_WIDTH;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   logic [LRR_WIDTH-1:0]             acc_ff, acc_in;
   logic [LRR_WIDTH-1:0]             opnd_ff, opnd_in;
   logic [LRR_WIDTH-1:0]             mcand_ff, mcand_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [LRR_WIDTH+DIGIT_WIDTH-1:0] prod;

   assign prod = mcand_ff * opnd_ff[DIGIT_WIDTH-1:0];

   always_comb begin
      acc_in   = acc_ff;
      opnd_in  = opnd_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = LCG_INC;
         opnd_in  = state_in;
         mcand_in = LCG_MUL;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in   = acc_ff + prod[LRR_WIDTH-1:0];
         opnd_in  = opnd_ff >> DIGIT_WIDTH;
         mcand_in = mcand_ff << DIGIT_WIDTH;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      opnd_ff  <= opnd_in;
      mcand_ff <= mcand_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result = acc_ff;
   assign done   = done_ff;

endmodule

### hdl/lrr_div.sv
// ----------------------------------------------------------------------------
// lrr_div
// Bit-serial restoring divider that returns the remainder.
// ----------------------------------------------------------------------------
module lrr_div
   import lrr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [LRR_WIDTH-1:0] dividend,
   input  logic [LRR_WIDTH-1:0] divisor,
   output logic [LRR_WIDTH-1:0] remainder,
   output logic                 done
);

   localparam int CNT_W = $clog2(LRR_WIDTH + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(LRR_WIDTH - 1);

   logic [LRR_WIDTH-1:0] rem_ff, rem_in;
   logic [LRR_WIDTH-1:0] dvd_ff, dvd_in;
   logic [LRR_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [LRR_WIDTH:0]   shifted;
   logic [LRR_WIDTH:0]   diff;

   assign shifted = {rem_ff, dvd_ff[LRR_WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[LRR_WIDTH] ? shifted[LRR_WIDTH-1:0] : diff[LRR_WIDTH-1:0];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

### hdl/lcg_random_range_unit.sv
// ----------------------------------------------------------------------------
// lcg_random_range_unit
// 32-bit LCG with raw, modulo and signed-range draws.
// ----------------------------------------------------------------------------
// One request at a time. The state advance runs one digit per cycle in the
// multiplier; modulo and range draws then go through the bit-serial divider.
// A raw draw or a zero span goes from the multiplier straight to the output
// state, a modulo or range draw passes the divider first. The response sits
// in an output register, so the next request is taken as soon as the
// previous response is loaded. Seed writes load the generator state and are
// always accepted.
// ----------------------------------------------------------------------------
module lcg_random_range_unit
   import lrr_pkg::*;
#(
   parameter int DIGIT_WIDTH = LRR_DIGIT_WIDTH
) (
   input  logic  clock,
   input  logic  reset,
   lrr_req_if.sink   req_if,
   lrr_rsp_if.source rsp_if,
   lrr_csr_if.sink   csr_if
);

   lrr_state_type state_ff, state_in;

   logic [LRR_WIDTH-1:0] gen_ff;
   logic [1:0]           cmd_ff;
   logic [LRR_WIDTH-1:0] lower_ff;
   logic [LRR_WIDTH-1:0] upper_ff;
   logic [LRR_WIDTH-1:0] res_ff;
   logic                 err_ff;
   logic                 rsp_valid_ff;
   logic [LRR_WIDTH-1:0] rsp_value_ff;
   logic                 rsp_zero_ff;

   logic                 req_fire;
   logic                 out_free;
   logic                 mul_start, div_start, out_load;
   logic                 mul_done, div_done;
   logic [LRR_WIDTH-1:0] mul_result, div_rem;
   logic                 is_mod, is_range, is_raw;
   logic [LRR_WIDTH-1:0] divisor;
   logic                 need_div;

   assign is_mod   = (cmd_ff == CMD_MOD);
   assign is_range = (cmd_ff == CMD_RANGE);
   assign is_raw   = !(is_mod || is_range);
   assign divisor  = is_range ? (upper_ff - lower_ff) : upper_ff;
   assign need_div = !is_raw && (divisor != '0);

   assign req_fire = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   lrr_mul #(
      .DIGIT_WIDTH(DIGIT_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .state_in(gen_ff),
      .result  (mul_result),
      .done    (mul_done)
   );

   lrr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_result),
      .divisor  (divisor),
      .remainder(div_rem),
      .done     (div_done)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) state_in = need_div ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            mul_start    = req_if.valid;
         end
         ST_MUL: begin
            div_start = mul_done && need_div;
         end
         ST_OUT: begin
            out_load = out_free;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_if.valid) begin
            gen_ff <= csr_if.data;
         end else if (state_ff == ST_MUL && mul_done) begin
            gen_ff <= mul_result;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_if.cmd;
         lower_ff <= req_if.lower;
         upper_ff <= req_if.upper;
      end
      if (state_ff == ST_MUL && mul_done && !need_div) begin
         res_ff <= is_raw ? mul_result : '0;
         err_ff <= !is_raw;
      end else if (state_ff == ST_DIV && div_done) begin
         res_ff <= div_rem + (is_range ? lower_ff : '0);
         err_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_value_ff <= res_ff;
         rsp_zero_ff  <= err_ff;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.value     = rsp_value_ff;
   assign rsp_if.zero_span = rsp_zero_ff;

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL)
      else $error("multiplier finished outside the advance phase");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide phase");

   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_MUL)
      else $error("accepted transaction did not start the advance");

   a_zero_span_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zero_ff) |-> rsp_value_ff == '0)
      else $error("zero span response carries a nonzero value");

endmodule
